@@ hdl/lbd_pkg.sv @@
package lbd_pkg;

   localparam int MAX_LEVEL = 7;

   localparam logic [7:0] BYTE_ADDR_FIXED = 8'h44;
   localparam logic [7:0] BYTE_ADDR_START = 8'hC0;
   localparam logic [7:0] BYTE_DISP_OFF   = 8'h80;
   localparam logic [7:0] BYTE_DISP_ON    = 8'h88;

   localparam logic [6:0] PCT_FULL = 7'd100;
   localparam logic [9:0] PCT_HALF = 10'd50;
   // x / 100 equals (x * 41) >> 12 for every x up to 750.
   localparam logic [15:0] PCT_RECIP = 16'd41;

   localparam logic [2:0] BRIGHT_DARK    = 3'd0;
   localparam logic [2:0] BRIGHT_TYPICAL = 3'd2;
   localparam logic [2:0] BRIGHT_MAX     = 3'd7;

   typedef enum logic [2:0] {
      ACT_INIT    = 3'd0,
      ACT_LEVEL   = 3'd1,
      ACT_PERCENT = 3'd2,
      ACT_BRIGHT  = 3'd3,
      ACT_ON      = 3'd4,
      ACT_OFF     = 3'd5
   } action_type;

   // Byte positions inside one command's burst.
   typedef enum logic [3:0] {
      STEP_MODE    = 4'b0001,
      STEP_ADDR    = 4'b0010,
      STEP_PATTERN = 4'b0100,
      STEP_CTRL    = 4'b1000
   } step_type;

   // One classified command waiting for the byte emitter.
   typedef struct packed {
      logic       has_level;
      logic       has_bright;
      logic       bright_on;
      logic [2:0] level;
      logic [2:0] bright;
   } job_type;

endpackage

@@ hdl/lbd_queue.sv @@
module lbd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  lbd_pkg::job_type push_job,
   output logic            full,
   input  logic            pop,
   output lbd_pkg::job_type head_job,
   output logic            empty
);
   import lbd_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/lbd_front.sv @@
module lbd_front #(
   parameter int MAX_LEVEL = lbd_pkg::MAX_LEVEL
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_action,
   input  logic [7:0]       req_value,
   input  logic             queue_full,
   output logic             push,
   output lbd_pkg::job_type push_job
);
   import lbd_pkg::*;

   logic [2:0]  level_ff;
   logic [2:0]  level_in;
   logic [2:0]  bright_ff;
   logic [2:0]  bright_in;
   logic        enabled_ff;
   logic        enabled_in;
   logic        accept;
   logic [6:0]  pct;
   logic [9:0]  pct_scaled;
   logic [15:0] pct_prod;
   logic [2:0]  pct_level;
   logic [2:0]  clamp_level;
   logic [2:0]  mapped_bright;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      pct         = (req_value > 8'(PCT_FULL)) ? PCT_FULL : req_value[6:0];
      pct_scaled  = 10'(pct) * 10'(MAX_LEVEL) + PCT_HALF;
      pct_prod    = 16'(pct_scaled) * PCT_RECIP;
      pct_level   = pct_prod[14:12];
      clamp_level = (req_value > 8'(MAX_LEVEL)) ? 3'(MAX_LEVEL) : req_value[2:0];
      if (req_value <= 8'd1) begin
         mapped_bright = BRIGHT_DARK;
      end else if (req_value == 8'd2) begin
         mapped_bright = BRIGHT_TYPICAL;
      end else begin
         mapped_bright = BRIGHT_MAX;
      end
   end

   always_comb begin
      level_in            = level_ff;
      bright_in           = bright_ff;
      enabled_in          = enabled_ff;
      push_job.has_level  = 1'b0;
      push_job.has_bright = 1'b0;
      push_job.bright_on  = 1'b1;
      unique case (req_action)
         ACT_INIT: begin
            bright_in           = BRIGHT_TYPICAL;
            push_job.has_level  = 1'b1;
            push_job.has_bright = 1'b1;
         end
         ACT_LEVEL: begin
            level_in           = clamp_level;
            push_job.has_level = enabled_ff;
         end
         ACT_PERCENT: begin
            level_in           = pct_level;
            push_job.has_level = enabled_ff;
         end
         ACT_BRIGHT: begin
            bright_in           = mapped_bright;
            push_job.has_level  = enabled_ff;
            push_job.has_bright = enabled_ff;
         end
         ACT_ON: begin
            enabled_in          = 1'b1;
            push_job.has_level  = 1'b1;
            push_job.has_bright = 1'b1;
         end
         ACT_OFF: begin
            enabled_in          = 1'b0;
            push_job.has_bright = 1'b1;
            push_job.bright_on  = 1'b0;
         end
         default: begin
         end
      endcase
      push_job.level  = level_in;
      push_job.bright = bright_in;
      push = accept && (push_job.has_level || push_job.has_bright);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 3'd0;
         bright_ff  <= BRIGHT_TYPICAL;
         enabled_ff <= 1'b1;
      end else if (accept) begin
         level_ff   <= level_in;
         bright_ff  <= bright_in;
         enabled_ff <= enabled_in;
      end
   end

endmodule

@@ hdl/lbd_back.sv @@
module lbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  lbd_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_frame_start,
   output logic             rsp_frame_end,
   output logic             rsp_last
);
   import lbd_pkg::*;

   logic       first_ff;
   logic       first_in;
   step_type   step_ff;
   step_type   step_in;
   step_type   cur_step;
   step_type   next_step;
   logic       advance;
   logic       is_last;
   logic [7:0] byte_val;
   logic       start_val;
   logic       end_val;
   logic [7:0] pattern;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       end_ff;
   logic       last_ff;

   assign advance = !queue_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      if (first_ff) begin
         cur_step = head_job.has_level ? STEP_MODE : STEP_CTRL;
      end else begin
         cur_step = step_ff;
      end
      pattern = 8'((9'd1 << head_job.level) - 9'd1);
      unique case (cur_step)
         STEP_MODE: begin
            byte_val  = BYTE_ADDR_FIXED;
            start_val = 1'b1;
            end_val   = 1'b1;
            next_step = STEP_ADDR;
         end
         STEP_ADDR: begin
            byte_val  = BYTE_ADDR_START;
            start_val = 1'b1;
            end_val   = 1'b0;
            next_step = STEP_PATTERN;
         end
         STEP_PATTERN: begin
            byte_val  = pattern;
            start_val = 1'b0;
            end_val   = 1'b1;
            next_step = STEP_CTRL;
         end
         STEP_CTRL: begin
            byte_val  = (head_job.bright_on ? BYTE_DISP_ON : BYTE_DISP_OFF)
                        | {5'd0, head_job.bright};
            start_val = 1'b1;
            end_val   = 1'b1;
            next_step = STEP_MODE;
         end
         default: begin
            byte_val  = 8'd0;
            start_val = 1'b0;
            end_val   = 1'b0;
            next_step = STEP_MODE;
         end
      endcase
      is_last = (cur_step == STEP_CTRL) ||
                ((cur_step == STEP_PATTERN) && !head_job.has_bright);
      pop      = advance && is_last;
      first_in = advance ? is_last : first_ff;
      step_in  = advance ? next_step : step_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         step_ff  <= STEP_MODE;
         valid_ff <= 1'b0;
      end else begin
         first_ff <= first_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff  <= byte_val;
         start_ff <= start_val;
         end_ff   <= end_val;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_bus_byte    = byte_ff;
   assign rsp_frame_start = start_ff;
   assign rsp_frame_end   = end_ff;
   assign rsp_last        = last_ff;

endmodule

@@ hdl/led_bar_display_command_sequencer.sv @@
// Command sequencer for a two-wire LED bar driver.
// The request channel (req_valid, req_stall, req_action, req_value) takes one
// display command per transfer: init, set level, set percent, set brightness,
// turn on or turn off. The block keeps the shown level, the brightness code
// and the enable flag, and turns each command into zero to four bus bytes.
// Each byte leaves on the response channel as one transfer, with frame start,
// frame end and last marks; last is set on the final byte of a command.
// With the emitter idle, the first byte of a command is registered in the job
// queue and then in the output register before it is offered. The emitter
// sends one byte per cycle while the queue holds a job and the receiver does
// not stall; the byte emitter is the throughput limit. A two-entry job queue
// sits between the command decoder and the emitter, so requests keep flowing
// while earlier bytes are still being sent.
// Reset clears the queue and the output register, sets the level to zero,
// the brightness code to typical and the display to enabled.
// When the receiver stalls, the current byte is held steady on the response
// ports; once the queue fills up, req_stall is raised.
module led_bar_display_command_sequencer #(
   parameter int MAX_LEVEL = lbd_pkg::MAX_LEVEL
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_frame_start,
   output logic       rsp_frame_end,
   output logic       rsp_last
);
   import lbd_pkg::*;

   // Handoff between the decoder and the queue, and between queue and emitter.
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type head_job;
   logic    queue_empty;

   // Decoder: updates the display state and classifies each command.
   lbd_front #(
      .MAX_LEVEL (MAX_LEVEL)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Commands that produce no bytes never enter the queue.
   lbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   // Emitter: walks the byte sequence of the head job into the output register.
   lbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last        (rsp_last)
   );

endmodule
